>>> hw/rtl/tope_pkg.sv
package tope_pkg;

  // Sizing of the tree entry format
  localparam int HASH_BYTES = 20;
  localparam int MODE_BITS  = 24;
  localparam int HCW        = (HASH_BYTES > 1) ? $clog2(HASH_BYTES) : 1;

  // Output field widths
  localparam int MODE_OUT_W = 24;

  // ASCII characters the parser looks for
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  typedef enum logic [1:0] {
    KIND_NAME = 2'd0,
    KIND_HASH = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_LEAD_ZERO  = 2'd1,
    ERR_EXP_SPACE  = 2'd2,
    ERR_HASH_TRUNC = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    PH_MODE = 4'b0001,
    PH_NAME = 4'b0010,
    PH_HASH = 4'b0100,
    PH_SKIP = 4'b1000
  } phase_t;

  // One input byte and its end-of-text mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result
  typedef struct packed {
    kind_t                   kind;
    logic [7:0]              name_char;
    logic [15:0]             hex_pair;
    logic [MODE_OUT_W-1:0]   entry_mode;
    logic                    entry_done;
    err_t                    error_code;
    logic                    list_end;
  } res_t;

  // Lower-case ASCII hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    return (nib < 4'd10) ? (CH_ZERO + n8) : (CH_LOW_A + n8 - 8'd10);
  endfunction

endpackage

>>> hw/rtl/tope_in_stage.sv
module tope_in_stage import tope_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       item_take,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  item_t item_r;

  // Refill when empty or when the held request is consumed this cycle
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

endmodule

>>> hw/rtl/tope_parse.sv
module tope_parse import tope_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  input  logic  item_valid,
  input  item_t item,
  input  logic  res_ready,
  output logic  item_take,
  output logic  res_valid,
  output res_t  res
);

  logic                 strict_r;
  phase_t               phase_r, phase_nxt;
  logic [MODE_BITS-1:0] mode_r, mode_nxt;
  logic                 start_r, start_nxt;
  logic [HCW-1:0]       hcnt_r, hcnt_nxt;

  logic [7:0]           b;
  logic                 last;
  logic                 is_digit;
  logic                 mode_ovf;
  logic [MODE_BITS-1:0] mode_acc;
  logic [HCW:0]         hash_n;
  logic                 hash_done;
  logic                 err;
  err_t                 err_code;
  logic                 restart;
  logic                 has_res;

  assign item_take = item_valid && res_ready;
  assign b         = item.data_byte;
  assign last      = item.last_byte;
  assign is_digit  = (b >= CH_ZERO) && (b <= CH_SEVEN);

  // mode * 8 + digit, saturating at all ones
  assign mode_ovf = |mode_r[MODE_BITS-1 -: 3];
  assign mode_acc = mode_ovf ? {MODE_BITS{1'b1}} : {mode_r[MODE_BITS-4:0], b[2:0]};

  assign hash_n    = {1'b0, hcnt_r} + (HCW+1)'(1);
  assign hash_done = hash_n >= (HCW+1)'(HASH_BYTES);

  // Per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    start_nxt = start_r;
    hcnt_nxt  = hcnt_r;
    err       = 1'b0;
    err_code  = ERR_NONE;
    restart   = 1'b0;
    has_res   = 1'b0;
    res       = '0;
    res.list_end = last;

    case (phase_r)
      PH_MODE: begin
        start_nxt = 1'b0;
        if (start_r && strict_r && (b == CH_ZERO)) begin
          err      = 1'b1;
          err_code = ERR_LEAD_ZERO;
        end else if (is_digit) begin
          mode_nxt = mode_acc;
          if (last) begin
            err      = 1'b1;
            err_code = ERR_EXP_SPACE;
          end
        end else if (b == CH_SPACE) begin
          if (last) begin
            err      = 1'b1;
            err_code = ERR_HASH_TRUNC;
          end else begin
            phase_nxt = PH_NAME;
          end
        end else begin
          err      = 1'b1;
          err_code = ERR_EXP_SPACE;
        end
      end
      PH_NAME: begin
        if (last) begin
          err      = 1'b1;
          err_code = ERR_HASH_TRUNC;
        end else if (b == CH_NUL) begin
          phase_nxt = PH_HASH;
          hcnt_nxt  = '0;
        end else begin
          has_res       = 1'b1;
          res.kind      = KIND_NAME;
          res.name_char = b;
        end
      end
      PH_HASH: begin
        if (!hash_done && last) begin
          err      = 1'b1;
          err_code = ERR_HASH_TRUNC;
        end else begin
          has_res      = 1'b1;
          res.kind     = KIND_HASH;
          res.hex_pair = {hex_digit(b[7:4]), hex_digit(b[3:0])};
          if (hash_done) begin
            res.entry_mode = MODE_OUT_W'(mode_r);
            res.entry_done = 1'b1;
            restart        = 1'b1;
          end else begin
            hcnt_nxt = hash_n[HCW-1:0];
          end
        end
      end
      PH_SKIP: begin
        restart = last;
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // Error result, then skip to the end of the text
    if (err) begin
      has_res        = 1'b1;
      res.kind       = KIND_ERR;
      res.error_code = err_code;
      if (last) begin
        restart = 1'b1;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end

    if (restart) begin
      phase_nxt = PH_MODE;
      mode_nxt  = '0;
      start_nxt = 1'b1;
      hcnt_nxt  = '0;
    end
  end

  assign res_valid = item_take && has_res;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= 1'b0;
    end else if (cfg_we) begin
      strict_r <= cfg_wdata;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MODE;
      mode_r  <= '0;
      start_r <= 1'b1;
      hcnt_r  <= '0;
    end else if (item_take) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      hcnt_r  <= hcnt_nxt;
    end
  end

endmodule

>>> hw/rtl/tope_out_skid.sv
module tope_out_skid import tope_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  res_t up_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic main_valid_r, skid_valid_r;
  res_t main_r, skid_r;
  logic push, drain;

  // Upstream ready comes straight from a flop
  assign up_ready  = !skid_valid_r;
  assign push      = up_valid && up_ready;
  assign drain     = out_ready || !main_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      main_valid_r <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves: skid to main first, else the new request; a push while stalled fills skid
  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= up_res;
      end
    end else if (push) begin
      skid_r <= up_res;
    end
  end

endmodule

>>> hw/rtl/tree_object_entry_parser_top.sv
// Tree object entry parser.
// Input channel: one byte of tree text per request (in_data_byte), with
// in_last_byte marking the final byte. Output channel: at most one result
// per byte: a name character, a hash byte as two lower-case hex characters
// (the final hash byte of an entry also carries the mode and entry_done),
// or an error code. Unless final, mode digits, the space and the NUL give none.
// cfg_we/cfg_wdata set strict_check, which rejects modes with a leading '0';
// write it only while the block is idle.
// Path: an accepted byte lands in the input register; its result, if any,
// then moves into the output register, or into the skid slot while
// out_ready is low, once the output stage has room for it.
// Throughput: one byte per cycle while the output stage keeps up, set by the
// combinational decode between the input register and the output stage.
// When out_ready is low the output stage holds one result and one more in
// its skid slot; in_ready then drops, after the input register fills.
// Reset (rst_n low, synchronous) empties both stages, clears strict_check
// and puts the parser at the start of an entry in the mode field.
module tree_object_entry_parser_top import tope_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_hex_pair,
  output logic [23:0] out_entry_mode,
  output logic        out_entry_done,
  output logic [1:0]  out_error_code,
  output logic        out_list_end,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic  item_take, item_valid;
  item_t item;
  logic  res_valid, res_ready;
  res_t  res, out_res;

  tope_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .item_take    (item_take),
    .item_valid   (item_valid),
    .item         (item)
  );

  tope_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  tope_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (res_valid),
    .up_ready  (res_ready),
    .up_res    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_name_char  = out_res.name_char;
  assign out_hex_pair   = out_res.hex_pair;
  assign out_entry_mode = out_res.entry_mode;
  assign out_entry_done = out_res.entry_done;
  assign out_error_code = out_res.error_code;
  assign out_list_end   = out_res.list_end;

endmodule

>>> hw/rtl/tope_checker.sv
module tope_checker import tope_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_data_byte,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_name_char,
  input logic [15:0] out_hex_pair,
  input logic [23:0] out_entry_mode,
  input logic        out_entry_done,
  input logic [1:0]  out_error_code,
  input logic        out_list_end
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_hex_pair) && $stable(out_name_char) && $stable(out_error_code) &&
      $stable(out_entry_mode) && $stable(out_entry_done) && $stable(out_list_end))
    else $error("stalled result changed");

  // Waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) &&
      $stable(in_last_byte))
    else $error("waiting request changed");

  // Error code only on error results
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ERR) |-> (out_error_code == ERR_NONE))
    else $error("error code on non-error result");

  // Entry done only on a hash result
  a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_done |-> (out_kind == KIND_HASH))
    else $error("entry_done on non-hash result");

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind tree_object_entry_parser_top tope_checker u_tope_checker (.*);

>>> tb/sv/tree_object_entry_parser_top_tb.sv
module tree_object_entry_parser_top_tb;
  import tope_pkg::*;

  localparam int              HOLD_CYCLES   = 300;
  localparam int              SETTLE_CYCLES = 8;
  localparam int              DRAIN_LIMIT   = 20000;
  localparam int              RAND_PER_PH   = 270;
  localparam longint unsigned MODE_MAX      = (64'd1 << MODE_BITS) - 64'd1;
  localparam res_t            NO_RES        = '0;

  // How a stimulus row is checked
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_RESULT
  } row_chk_t;

  typedef struct {
    bit         wr_strict;
    bit         strict_val;
    logic [7:0] data;
    bit         last;
    row_chk_t   chk;
    res_t       res;
  } stim_row_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_name_char;
  logic [15:0] out_hex_pair;
  logic [23:0] out_entry_mode;
  logic        out_entry_done;
  logic [1:0]  out_error_code;
  logic        out_list_end;
  logic        cfg_we       = 1'b0;
  logic        cfg_wdata    = 1'b0;

  // Parser model state
  phase_t               cur_ph;
  logic [MODE_BITS-1:0] mode_acc;
  bit                   at_entry_start;
  int unsigned          hash_n;
  bit                   strict_q;

  res_t      pending_results[$];
  res_t      want;
  stim_row_t dir_rows[$];
  int        mismatches   = 0;
  int        sent_bytes   = 0;
  int        in_idle_pct  = 0;
  int        stall_pct    = 0;
  int        hold_reqs    = 0;
  int        hold_served  = 0;
  int        hold_left    = 0;

  tree_object_entry_parser_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_name_char  (out_name_char),
    .out_hex_pair   (out_hex_pair),
    .out_entry_mode (out_entry_mode),
    .out_entry_done (out_entry_done),
    .out_error_code (out_error_code),
    .out_list_end   (out_list_end),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned exp_val);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, exp_val, $time);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------
  function automatic void reset_entry();
    cur_ph         = PH_MODE;
    mode_acc       = '0;
    at_entry_start = 1'b1;
    hash_n         = 0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return 8'h61 + {4'd0, nib} - 8'd10;
  endfunction

  function automatic res_t err_res(input err_t code, input bit lst);
    res_t r;
    r            = NO_RES;
    r.kind       = KIND_ERR;
    r.error_code = code;
    r.list_end   = lst;
    return r;
  endfunction

  function automatic res_t name_res(input logic [7:0] b);
    res_t r;
    r           = NO_RES;
    r.kind      = KIND_NAME;
    r.name_char = b;
    return r;
  endfunction

  function automatic res_t hex_res(input logic [15:0] h);
    res_t r;
    r          = NO_RES;
    r.kind     = KIND_HASH;
    r.hex_pair = h;
    return r;
  endfunction

  // Error result; parser skips to the end of the text unless this byte is it
  function automatic res_t abort_entry(input err_t code, input bit lst);
    if (lst) reset_entry();
    else cur_ph = PH_SKIP;
    return err_res(code, lst);
  endfunction

  // Advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, input bit lst, output res_t r);
    bit              first;
    int unsigned     n;
    longint unsigned acc;
    r = NO_RES;
    case (cur_ph)
      PH_MODE: begin
        first          = at_entry_start;
        at_entry_start = 1'b0;
        if (first && strict_q && b == CH_ZERO) begin
          r = abort_entry(ERR_LEAD_ZERO, lst);
          return 1'b1;
        end
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          acc      = longint'(mode_acc) * 8 + longint'(b - CH_ZERO);
          mode_acc = (acc > MODE_MAX) ? MODE_MAX[MODE_BITS-1:0] : acc[MODE_BITS-1:0];
          if (lst) begin
            r = abort_entry(ERR_EXP_SPACE, lst);
            return 1'b1;
          end
          return 1'b0;
        end
        if (b == CH_SPACE) begin
          if (lst) begin
            r = abort_entry(ERR_HASH_TRUNC, lst);
            return 1'b1;
          end
          cur_ph = PH_NAME;
          return 1'b0;
        end
        r = abort_entry(ERR_EXP_SPACE, lst);
        return 1'b1;
      end
      PH_NAME: begin
        if (lst) begin
          r = abort_entry(ERR_HASH_TRUNC, lst);
          return 1'b1;
        end
        if (b == CH_NUL) begin
          cur_ph = PH_HASH;
          hash_n = 0;
          return 1'b0;
        end
        r = name_res(b);
        return 1'b1;
      end
      PH_HASH: begin
        n = hash_n + 1;
        if (n < HASH_BYTES && lst) begin
          r = abort_entry(ERR_HASH_TRUNC, lst);
          return 1'b1;
        end
        r          = hex_res({hex_char(b[7:4]), hex_char(b[3:0])});
        r.list_end = lst;
        if (n >= HASH_BYTES) begin
          r.entry_mode = mode_acc[MODE_OUT_W-1:0];
          r.entry_done = 1'b1;
          reset_entry();
        end else begin
          hash_n = n;
        end
        return 1'b1;
      end
      default: begin
        if (lst) reset_entry();
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] d, input bit lst, input row_chk_t chk,
                           input res_t typed);
    res_t r;
    bit   has;
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= lst;
    do @(posedge clk); while (in_ready !== 1'b1);
    has = parse_byte(d, lst, r);
    sent_bytes++;
    case (chk)
      ROW_PREDICT: if (has) pending_results.push_back(r);
      ROW_RESULT:  pending_results.push_back(typed);
      default:     ;
    endcase
  endtask

  // Stop sending, let every expected result arrive, then let the pipe settle
  task automatic drain_pipe();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (pending_results.size() != 0) begin
      flag_mismatch("results missing", 0, pending_results.size());
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_strict(input bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    strict_q  = v;
  endtask

  task automatic add_row(input bit wr, input bit sv, input logic [7:0] d, input bit lst,
                         input row_chk_t chk, input res_t r);
    stim_row_t row;
    row.wr_strict  = wr;
    row.strict_val = sv;
    row.data       = d;
    row.last       = lst;
    row.chk        = chk;
    row.res        = r;
    dir_rows.push_back(row);
  endtask

  // One random tree text: mostly well-formed entries, some cut short or
  // corrupted, some plain noise
  task automatic send_text();
    logic [7:0] txt[$];
    int         style;
    int         sel;
    int         ndig;
    int         cut;
    int         pos;
    style = $urandom_range(99);
    if (style >= 85) begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        sel = $urandom_range(9);
        if (sel == 0) ndig = 0;
        else if (sel == 1) ndig = $urandom_range(8, 11);
        else ndig = $urandom_range(1, 6);
        for (int k = 0; k < ndig; k++)
          txt.push_back((sel == 1) ? CH_SEVEN : CH_ZERO + 8'($urandom_range(0, 7)));
        txt.push_back(CH_SPACE);
        repeat ($urandom_range(0, 5)) txt.push_back(8'($urandom_range(1, 255)));
        txt.push_back(CH_NUL);
        repeat (HASH_BYTES) txt.push_back(8'($urandom_range(0, 255)));
      end
      if (style >= 70) begin
        cut = $urandom_range(0, txt.size() - 1);
        while (txt.size() > cut + 1) void'(txt.pop_back());
        if ($urandom_range(1) == 1) begin
          pos      = $urandom_range(0, cut);
          txt[pos] = 8'($urandom_range(0, 255));
        end
      end
    end
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1, ROW_PREDICT, NO_RES);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_served != hold_reqs) begin
      hold_served <= hold_reqs;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result, kind", out_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_kind !== want.kind) flag_mismatch("kind", out_kind, want.kind);
        if (out_name_char !== want.name_char)
          flag_mismatch("name_char", out_name_char, want.name_char);
        if (out_hex_pair !== want.hex_pair)
          flag_mismatch("hex_pair", out_hex_pair, want.hex_pair);
        if (out_entry_mode !== want.entry_mode)
          flag_mismatch("entry_mode", out_entry_mode, want.entry_mode);
        if (out_entry_done !== want.entry_done)
          flag_mismatch("entry_done", out_entry_done, want.entry_done);
        if (out_error_code !== want.error_code)
          flag_mismatch("error_code", out_error_code, want.error_code);
        if (out_list_end !== want.list_end)
          flag_mismatch("list_end", out_list_end, want.list_end);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int ph_idle[4];
    int ph_stall[4];
    bit quiet;
    ph_idle  = '{0, 55, 0, 32};
    ph_stall = '{0, 0, 55, 32};
    strict_q = 1'b0;
    reset_entry();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: error paths, field extremes, leading zero under strict
    add_row(0, 0, "9",   0, ROW_RESULT,    err_res(ERR_EXP_SPACE, 0));
    add_row(0, 0, 8'hFF, 1, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, "7",   1, ROW_RESULT,    err_res(ERR_EXP_SPACE, 1));
    add_row(0, 0, " ",   1, ROW_RESULT,    err_res(ERR_HASH_TRUNC, 1));
    add_row(0, 0, " ",   0, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, "A",   1, ROW_RESULT,    err_res(ERR_HASH_TRUNC, 1));
    add_row(0, 0, "0",   0, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, "7",   0, ROW_PREDICT,   NO_RES);
    add_row(0, 0, " ",   0, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, 8'hFF, 0, ROW_RESULT,    name_res(8'hFF));
    add_row(0, 0, 8'h01, 0, ROW_RESULT,    name_res(8'h01));
    add_row(0, 0, 8'h00, 0, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, 8'h00, 0, ROW_RESULT,    hex_res(16'h3030));
    add_row(0, 0, 8'hFF, 0, ROW_RESULT,    hex_res(16'h6666));
    add_row(0, 0, 8'hA5, 1, ROW_RESULT,    err_res(ERR_HASH_TRUNC, 1));
    add_row(1, 1, "0",   0, ROW_RESULT,    err_res(ERR_LEAD_ZERO, 0));
    add_row(0, 0, 8'h00, 1, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, "0",   1, ROW_RESULT,    err_res(ERR_LEAD_ZERO, 1));
    add_row(0, 0, "1",   0, ROW_NO_RESULT, NO_RES);
    add_row(0, 0, "0",   0, ROW_PREDICT,   NO_RES);
    add_row(0, 0, "/",   0, ROW_RESULT,    err_res(ERR_EXP_SPACE, 0));
    add_row(0, 0, "8",   1, ROW_NO_RESULT, NO_RES);
    add_row(1, 0, " ",   0, ROW_PREDICT,   NO_RES);
    add_row(0, 0, 8'h00, 0, ROW_PREDICT,   NO_RES);
    add_row(0, 0, 8'h7F, 1, ROW_RESULT,    err_res(ERR_HASH_TRUNC, 1));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_strict) begin
        drain_pipe();
        write_strict(dir_rows[i].strict_val);
      end
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].chk, dir_rows[i].res);
    end

    // Random texts under each input-idle and output-stall profile, strict toggled per phase
    for (int ph = 0; ph < 4; ph++) begin
      drain_pipe();
      write_strict(ph[0]);
      if (ph == 0) hold_reqs++;
      sent_bytes = 0;
      while (sent_bytes < RAND_PER_PH) begin
        quiet       = ($urandom_range(4) == 0);
        in_idle_pct = quiet ? 0 : ph_idle[ph];
        stall_pct   = quiet ? 0 : ph_stall[ph];
        send_text();
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tope_pkg.sv
hw/rtl/tope_in_stage.sv
hw/rtl/tope_parse.sv
hw/rtl/tope_out_skid.sv
hw/rtl/tree_object_entry_parser_top.sv
hw/rtl/tope_checker.sv
tb/sv/tree_object_entry_parser_top_tb.sv
